### design/gtp_pkg.sv
`timescale 1ns / 1ps

package gtp_pkg;

   localparam int POS_W      = 32;
   localparam int HDG_W      = 16;
   localparam int DTOL_W     = 31;
   localparam int HTOL_W     = 15;
   localparam int SPD_W      = 20;
   localparam int ANG_CMD_W  = 21;
   localparam int STATUS_W   = 3;
   localparam int MODE_W     = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int SQ_W       = 64;
   // cordic datapath: |x| grows to about 1.65 * sqrt(2) * 2^31
   localparam int CORDIC_W   = 36;
   localparam int ATAN_IDX_W = 5;

   localparam logic [HDG_W-1:0] HALF_TURN = 16'h8000;

   typedef enum logic [MODE_W-1:0] {
      MODE_ODOM   = 2'd0,
      MODE_GOAL   = 2'd1,
      MODE_CANCEL = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_IDLE     = 3'd0,
      STAT_ACCEPTED = 3'd1,
      STAT_TURNING  = 3'd2,
      STAT_DRIVING  = 3'd3,
      STAT_REACHED  = 3'd4,
      STAT_CANCELED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_DIST_TOL  = 2'd0,
      REG_HEAD_TOL  = 2'd1,
      REG_DRIVE_SPD = 2'd2,
      REG_TURN_SPD  = 2'd3
   } cfg_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_T,
      ST_CMP,
      ST_ATAN,
      ST_EMIT
   } state_type;

   localparam logic [DTOL_W-1:0] DTOL_RESET  = 31'd3277;
   localparam logic [HTOL_W-1:0] HTOL_RESET  = 15'd364;
   localparam logic [SPD_W-1:0]  DRIVE_RESET = 20'd39322;
   localparam logic [SPD_W-1:0]  TURN_RESET  = 20'd42598;

   // atan(2^-i) in binary angle units, 65536 per turn
   function automatic logic [HDG_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
      logic [HDG_W-1:0] a;
      case (idx)
         5'd0:    a = 16'd8192;
         5'd1:    a = 16'd4836;
         5'd2:    a = 16'd2555;
         5'd3:    a = 16'd1297;
         5'd4:    a = 16'd651;
         5'd5:    a = 16'd326;
         5'd6:    a = 16'd163;
         5'd7:    a = 16'd81;
         5'd8:    a = 16'd41;
         5'd9:    a = 16'd20;
         5'd10:   a = 16'd10;
         5'd11:   a = 16'd5;
         5'd12:   a = 16'd3;
         5'd13:   a = 16'd1;
         5'd14:   a = 16'd1;
         default: a = 16'd0;
      endcase
      return a;
   endfunction

   // clamp a 33-bit signed sum to the signed 32-bit range
   function automatic logic signed [POS_W-1:0] sat33(input logic signed [POS_W:0] s);
      logic signed [POS_W-1:0] r;
      if (s[POS_W] != s[POS_W-1]) begin
         r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         r = s[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

### design/gtp_cordic.sv
`timescale 1ns / 1ps

module gtp_cordic #(
   parameter int STEPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [gtp_pkg::POS_W-1:0]    dx,
   input  logic signed [gtp_pkg::POS_W-1:0]    dy,
   output logic                                done,
   output logic        [gtp_pkg::HDG_W-1:0]    angle
);
   import gtp_pkg::*;

   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           step_ff, step_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic [HDG_W-1:0]           z_ff, z_in;

   logic signed [CORDIC_W-1:0] x0, y0, xs, ys;
   logic [HDG_W-1:0]           rot;

   assign x0  = CORDIC_W'(dx);
   assign y0  = CORDIC_W'(dy);
   assign xs  = x_ff >>> step_ff;
   assign ys  = y_ff >>> step_ff;
   assign rot = atan_lookup(ATAN_IDX_W'(step_ff));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         step_in = '0;
         if (dx == '0 && dy == '0) begin
            // no bearing for a zero vector, report zero at once
            z_in    = '0;
            done_in = 1'b1;
         end else if (dx[POS_W-1]) begin
            x_in    = -x0;
            y_in    = -y0;
            z_in    = HALF_TURN;
            busy_in = 1'b1;
         end else begin
            x_in    = x0;
            y_in    = y0;
            z_in    = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + rot;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - rot;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

### design/go_to_point_heading_controller.sv
`timescale 1ns / 1ps

// sequencing: goal, cancel, unused-mode and goal-less odometry items go straight from
//   acceptance to the emit state; an odometry item with an armed goal passes the difference,
//   squaring and compare states, then the cordic unless the goal is reached
// throughput: one item at a time, set by the shared squaring multiplier and the
//   one-iteration-per-cycle cordic unit
// reset: synchronous; positions and target clear, goal disarmed, registers to defaults
module go_to_point_heading_controller #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [gtp_pkg::MODE_W-1:0]             req_mode,
   input  logic signed [gtp_pkg::POS_W-1:0]       req_x_value,
   input  logic signed [gtp_pkg::POS_W-1:0]       req_y_value,
   input  logic signed [gtp_pkg::HDG_W-1:0]       req_heading,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [gtp_pkg::SPD_W-1:0]              rsp_linear_cmd,
   output logic signed [gtp_pkg::ANG_CMD_W-1:0]   rsp_angular_cmd,
   output logic [gtp_pkg::STATUS_W-1:0]           rsp_status,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [gtp_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [gtp_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [gtp_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);
   import gtp_pkg::*;

   localparam int CORDIC_MAX = 24;
   localparam int STEPS = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;

   state_type                 state_ff, state_in;
   logic signed [POS_W-1:0]   last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic signed [POS_W-1:0]   target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic                      goal_ff, goal_in;
   logic [HDG_W-1:0]          hd_ff, hd_in;
   logic signed [POS_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]           prod_ff, prod_in, d2_ff, d2_in;
   logic [SPD_W-1:0]          res_lin_ff, res_lin_in;
   logic signed [ANG_CMD_W-1:0] res_ang_ff, res_ang_in;
   logic [STATUS_W-1:0]       res_st_ff, res_st_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SPD_W-1:0]          rsp_lin_ff, rsp_lin_in;
   logic signed [ANG_CMD_W-1:0] rsp_ang_ff, rsp_ang_in;
   logic [STATUS_W-1:0]       rsp_st_ff, rsp_st_in;
   logic [DTOL_W-1:0]         dtol_ff, dtol_in;
   logic [HTOL_W-1:0]         htol_ff, htol_in;
   logic [SPD_W-1:0]          dspd_ff, dspd_in;
   logic [SPD_W-1:0]          tspd_ff, tspd_in;

   logic                      accept, csr_wr;
   logic [POS_W-1:0]          ax, ay, mul_a;
   logic [SQ_W-1:0]           mul_p;
   logic                      cordic_start, cordic_done;
   logic [HDG_W-1:0]          bearing, eu, mag;
   logic                      err_pos, turn;
   logic signed [ANG_CMD_W-1:0] tspd_s;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;

   assign ax = dx_ff[POS_W-1] ? POS_W'(-dx_ff) : POS_W'(dx_ff);
   assign ay = dy_ff[POS_W-1] ? POS_W'(-dy_ff) : POS_W'(dy_ff);

   // one squaring multiplier shared by both distance terms and the tolerance
   always_comb begin
      case (state_ff)
         ST_SQ_X: mul_a = ax;
         ST_SQ_Y: mul_a = ay;
         default: mul_a = POS_W'(dtol_ff);
      endcase
   end
   assign mul_p = SQ_W'(mul_a) * SQ_W'(mul_a);

   gtp_cordic #(
      .STEPS (STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .dx    (dx_ff),
      .dy    (dy_ff),
      .done  (cordic_done),
      .angle (bearing)
   );

   // heading error wraps for free; exactly half a turn counts as positive
   assign eu      = bearing - hd_ff;
   assign err_pos = (eu != '0) && (!eu[HDG_W-1] || eu == HALF_TURN);
   assign mag     = eu[HDG_W-1] ? HDG_W'(-eu) : eu;
   assign turn    = mag > HDG_W'(htol_ff);
   assign tspd_s  = ANG_CMD_W'(tspd_ff);

   always_comb begin
      state_in    = state_ff;
      last_x_in   = last_x_ff;
      last_y_in   = last_y_ff;
      target_x_in = target_x_ff;
      target_y_in = target_y_ff;
      goal_in     = goal_ff;
      hd_in       = hd_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      prod_in     = prod_ff;
      d2_in       = d2_ff;
      res_lin_in  = res_lin_ff;
      res_ang_in  = res_ang_ff;
      res_st_in   = res_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_lin_in  = rsp_lin_ff;
      rsp_ang_in  = rsp_ang_ff;
      rsp_st_in   = rsp_st_ff;
      cordic_start = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_lin_in = '0;
               res_ang_in = '0;
               res_st_in  = STAT_IDLE;
               state_in   = ST_EMIT;
               unique case (mode_type'(req_mode))
                  MODE_GOAL: begin
                     target_x_in = sat33((POS_W+1)'(last_x_ff) + (POS_W+1)'(req_x_value));
                     target_y_in = sat33((POS_W+1)'(last_y_ff) + (POS_W+1)'(req_y_value));
                     goal_in     = 1'b1;
                     res_st_in   = STAT_ACCEPTED;
                  end
                  MODE_CANCEL: begin
                     goal_in   = 1'b0;
                     res_st_in = STAT_CANCELED;
                  end
                  MODE_ODOM: begin
                     last_x_in = req_x_value;
                     last_y_in = req_y_value;
                     hd_in     = req_heading;
                     if (goal_ff) begin
                        state_in = ST_DIFF;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIFF: begin
            dx_in    = sat33((POS_W+1)'(target_x_ff) - (POS_W+1)'(last_x_ff));
            dy_in    = sat33((POS_W+1)'(target_y_ff) - (POS_W+1)'(last_y_ff));
            state_in = ST_SQ_X;
         end
         ST_SQ_X: begin
            prod_in  = mul_p;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            d2_in    = prod_ff;
            prod_in  = mul_p;
            state_in = ST_SQ_T;
         end
         ST_SQ_T: begin
            d2_in    = d2_ff + prod_ff;
            prod_in  = mul_p;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // squared distance against squared tolerance, strict
            if (d2_ff < prod_ff) begin
               goal_in   = 1'b0;
               res_st_in = STAT_REACHED;
               state_in  = ST_EMIT;
            end else begin
               cordic_start = 1'b1;
               state_in = ST_ATAN;
            end
         end
         ST_ATAN: begin
            if (cordic_done) begin
               if (turn) begin
                  res_lin_in = '0;
                  res_ang_in = err_pos ? tspd_s : -tspd_s;
                  res_st_in  = STAT_TURNING;
               end else begin
                  res_lin_in = dspd_ff;
                  res_ang_in = '0;
                  res_st_in  = STAT_DRIVING;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_lin_in   = res_lin_ff;
               rsp_ang_in   = res_ang_ff;
               rsp_st_in    = res_st_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dtol_in = dtol_ff;
      htol_in = htol_ff;
      dspd_in = dspd_ff;
      tspd_in = tspd_ff;
      if (csr_wr) begin
         unique case (cfg_reg_type'(csr_paddr[3:2]))
            REG_DIST_TOL:  dtol_in = csr_pwdata[DTOL_W-1:0];
            REG_HEAD_TOL:  htol_in = csr_pwdata[HTOL_W-1:0];
            REG_DRIVE_SPD: dspd_in = csr_pwdata[SPD_W-1:0];
            REG_TURN_SPD:  tspd_in = csr_pwdata[SPD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (cfg_reg_type'(csr_paddr[3:2]))
         REG_DIST_TOL:  csr_prdata = CSR_DATA_W'(dtol_ff);
         REG_HEAD_TOL:  csr_prdata = CSR_DATA_W'(htol_ff);
         REG_DRIVE_SPD: csr_prdata = CSR_DATA_W'(dspd_ff);
         REG_TURN_SPD:  csr_prdata = CSR_DATA_W'(tspd_ff);
         default:       csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         target_x_ff  <= '0;
         target_y_ff  <= '0;
         goal_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dtol_ff      <= DTOL_RESET;
         htol_ff      <= HTOL_RESET;
         dspd_ff      <= DRIVE_RESET;
         tspd_ff      <= TURN_RESET;
      end else begin
         state_ff     <= state_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         target_x_ff  <= target_x_in;
         target_y_ff  <= target_y_in;
         goal_ff      <= goal_in;
         rsp_valid_ff <= rsp_valid_in;
         dtol_ff      <= dtol_in;
         htol_ff      <= htol_in;
         dspd_ff      <= dspd_in;
         tspd_ff      <= tspd_in;
      end
   end

   always_ff @(posedge clock) begin
      hd_ff      <= hd_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      prod_ff    <= prod_in;
      d2_ff      <= d2_in;
      res_lin_ff <= res_lin_in;
      res_ang_ff <= res_ang_in;
      res_st_ff  <= res_st_in;
      rsp_lin_ff <= rsp_lin_in;
      rsp_ang_ff <= rsp_ang_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_linear_cmd  = rsp_lin_ff;
   assign rsp_angular_cmd = rsp_ang_ff;
   assign rsp_status      = rsp_st_ff;

endmodule
